[rtl/timer_queue_scheduler_unit_defines.svh]
// Assertion macros shared by the timer queue scheduler checker.
`ifndef TIMER_QUEUE_SCHEDULER_UNIT_DEFINES_SVH
`define TIMER_QUEUE_SCHEDULER_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TQS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tqs check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define TQS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tqs check failed");

`endif

[rtl/tqs_pkg.sv]
// Package with types and constants of the timer queue scheduler.
`timescale 1ns / 1ps
package tqs_pkg;
    localparam int TIMERS = 16;
    localparam int IDX_W  = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CNT_W  = $clog2(TIMERS + 1);

    localparam int DELAY_W = 24;
    localparam int ID_W    = 31;
    localparam int TIME_W  = 32;
    localparam int DL_W    = 33;
    localparam int IN_W    = 88;
    localparam int OUT_W   = 64;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SELECT = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_FIRE   = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_DELAY = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_REM_SCAN,
        S_SEL_SCAN,
        S_SEL_DECIDE,
        S_SEL_UPD,
        S_SEL_DIV,
        S_EMIT
    } state_t;
endpackage

[rtl/tqs_rem.sv]
// Iterative restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
module tqs_rem
    import tqs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [TIME_W-1:0]  dividend,
    input  logic [DELAY_W-1:0] divisor,
    output logic               done,
    output logic [DELAY_W-1:0] remainder
);
    localparam int STEP_W = $clog2(TIME_W + 1);

    logic [TIME_W-1:0]  num_reg;
    logic [DELAY_W:0]   rem_reg;
    logic [DELAY_W-1:0] div_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DELAY_W:0]   shifted;
    logic [DELAY_W:0]   diff;

    assign shifted = {rem_reg[DELAY_W-1:0], num_reg[TIME_W-1]};
    assign diff    = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(TIME_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[TIME_W-2:0], 1'b0};
            rem_reg <= diff[DELAY_W] ? shifted : diff;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[DELAY_W-1:0];
endmodule

[rtl/timer_queue_scheduler_unit.sv]
// Top level of the timer queue scheduler: timer table, sequencer and result register.
//  channel | dir | tdata                                                 | tuser   | tlast
//  s_axis  | in  | delay_ms, periodic, timer_id, now_ms                  | command | -
//  m_axis  | out | status, fired_or_new_id, next_delay_ms, next_valid    | kind    | last
// Add: an update state, then the result beat. Remove: a scan of up to TIMERS slots, then the beat.
// Select, per fired timer: a scan of all slots, a decide state, the fire beat, an update state,
// plus the remainder unit for a periodic timer; then a final scan, decide and the finish beat.
// One item is worked at a time; s_tready is high only while idle.
// A stalled output beat holds the sequencer. Reset clears the valid and fresh bits.
`timescale 1ns / 1ps
module timer_queue_scheduler_unit
    import tqs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // delay_ms, periodic, timer_id, now_ms
    input  logic [1:0]       s_tuser,   // command
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // status, fired_or_new_id, next_delay_ms, next_valid
    output logic [1:0]       m_tuser,   // kind
    output logic             m_tlast
);
    state_t state_reg, state_next, ret_reg;

    logic [DL_W-1:0]    dl_reg [TIMERS];
    logic [DELAY_W-1:0] iv_reg [TIMERS];
    logic [ID_W-1:0]    id_reg [TIMERS];
    logic [TIMERS-1:0]  valid_reg;
    logic [TIMERS-1:0]  fresh_reg;
    logic [ID_W-1:0]    idc_reg;
    logic [DELAY_W-1:0] pend_reg;
    logic               pend_valid_reg;

    logic [DELAY_W-1:0] delay_reg;
    logic               periodic_reg;
    logic [ID_W-1:0]    tid_reg;
    logic [TIME_W-1:0]  now_reg;

    logic [IDX_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               bfound_reg;
    logic [DL_W-1:0]    bd_reg;
    logic [ID_W-1:0]    bid_reg;
    logic [IDX_W-1:0]   bslot_reg;
    logic               bfresh_reg;
    logic [DELAY_W-1:0] biv_reg;

    logic [1:0]         o_kind_reg;
    logic [1:0]         o_status_reg;
    logic [ID_W-1:0]    o_id_reg;
    logic [DELAY_W-1:0] o_delay_reg;
    logic               o_valid_reg;
    logic               o_last_reg;

    logic               in_fire;
    logic               out_fire;
    logic               idx_last;
    logic               take;
    logic               rem_match;
    logic               stop;
    logic               has_free;
    logic [IDX_W-1:0]   free_slot;
    logic [ID_W-1:0]    new_id;
    logic [DL_W-1:0]    gap;
    logic [DELAY_W-1:0] fin_delay;
    logic               div_start;
    logic               div_done;
    logic [DELAY_W-1:0] div_rem;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign idx_last = (idx_reg == IDX_W'(TIMERS - 1));

    assign take = valid_reg[idx_reg] && (!bfound_reg || dl_reg[idx_reg] < bd_reg ||
                  (dl_reg[idx_reg] == bd_reg && id_reg[idx_reg] < bid_reg));
    assign rem_match = valid_reg[idx_reg] && (id_reg[idx_reg] == tid_reg);
    assign stop = !bfound_reg || (bd_reg > {1'b0, now_reg}) || bfresh_reg ||
                  (cnt_reg == CNT_W'(TIMERS));
    assign gap = bd_reg - {1'b0, now_reg};

    always_comb
    begin
        if (bd_reg <= {1'b0, now_reg})
            fin_delay = DELAY_W'(1);
        else if (gap[DL_W-1:DELAY_W] != '0)
            fin_delay = '1;
        else
            fin_delay = gap[DELAY_W-1:0];
    end

    always_comb
    begin
        has_free  = 1'b0;
        free_slot = '0;
        for (int i = TIMERS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                has_free  = 1'b1;
                free_slot = IDX_W'(i);
            end
        end
    end

    assign new_id = (idc_reg == '0) ? ID_W'(1) : idc_reg;

    tqs_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (now_reg - bd_reg[TIME_W-1:0]),
        .divisor   (biv_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (s_tuser)
                        CMD_ADD:    state_next = S_ADD;
                        CMD_REMOVE: state_next = S_REM_SCAN;
                        CMD_SELECT: state_next = S_SEL_SCAN;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:        state_next = S_EMIT;
            S_REM_SCAN:   state_next = (rem_match || idx_last) ? S_EMIT : S_REM_SCAN;
            S_SEL_SCAN:   state_next = idx_last ? S_SEL_DECIDE : S_SEL_SCAN;
            S_SEL_DECIDE: state_next = S_EMIT;
            S_SEL_UPD:    state_next = (biv_reg != '0) ? S_SEL_DIV : S_SEL_SCAN;
            S_SEL_DIV:    state_next = div_done ? S_SEL_SCAN : S_SEL_DIV;
            S_EMIT:       state_next = out_fire ? ret_reg : S_EMIT;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            S_IDLE:    s_tready  = 1'b1;
            S_SEL_UPD: div_start = (biv_reg != '0);
            S_EMIT:    m_tvalid  = 1'b1;
            default:   s_tready  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            valid_reg      <= '0;
            fresh_reg      <= '0;
            idc_reg        <= ID_W'(1);
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            bfound_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg    <= '0;
                    cnt_reg    <= '0;
                    bfound_reg <= 1'b0;
                end
                S_ADD:
                begin
                    ret_reg <= S_IDLE;
                    if (delay_reg != '0 && has_free)
                    begin
                        if (!pend_valid_reg || pend_reg > delay_reg)
                        begin
                            pend_reg       <= delay_reg;
                            pend_valid_reg <= 1'b1;
                        end
                        idc_reg              <= (idc_reg == '0) ? ID_W'(2) : idc_reg + 1'b1;
                        valid_reg[free_slot] <= 1'b1;
                        fresh_reg[free_slot] <= 1'b1;
                    end
                end
                S_REM_SCAN:
                begin
                    ret_reg <= S_IDLE;
                    idx_reg <= idx_reg + 1'b1;
                    if (rem_match)
                    begin
                        valid_reg[idx_reg] <= 1'b0;
                        fresh_reg[idx_reg] <= 1'b0;
                    end
                end
                S_SEL_SCAN:
                begin
                    idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
                    if (take)
                        bfound_reg <= 1'b1;
                end
                S_SEL_DECIDE:
                begin
                    if (stop)
                    begin
                        ret_reg        <= S_IDLE;
                        fresh_reg      <= '0;
                        pend_valid_reg <= bfound_reg;
                        pend_reg       <= bfound_reg ? fin_delay : '0;
                    end
                    else
                    begin
                        ret_reg <= S_SEL_UPD;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_SEL_UPD:
                begin
                    bfound_reg <= 1'b0;
                    if (biv_reg == '0)
                        valid_reg[bslot_reg] <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    delay_reg    <= s_tdata[23:0];
                    periodic_reg <= s_tdata[24];
                    tid_reg      <= s_tdata[55:25];
                    now_reg      <= s_tdata[87:56];
                end
            end
            S_ADD:
            begin
                o_kind_reg  <= KIND_ADD;
                o_last_reg  <= 1'b1;
                o_delay_reg <= pend_reg;
                o_valid_reg <= pend_valid_reg;
                o_id_reg    <= '0;
                if (delay_reg == '0)
                    o_status_reg <= ST_BAD_DELAY;
                else if (!has_free)
                    o_status_reg <= ST_FULL;
                else
                begin
                    o_status_reg      <= ST_OK;
                    o_id_reg          <= new_id;
                    dl_reg[free_slot] <= {1'b0, now_reg} + DL_W'(delay_reg);
                    iv_reg[free_slot] <= periodic_reg ? delay_reg : '0;
                    id_reg[free_slot] <= new_id;
                    if (!pend_valid_reg || pend_reg > delay_reg)
                    begin
                        o_delay_reg <= delay_reg;
                        o_valid_reg <= 1'b1;
                    end
                end
            end
            S_REM_SCAN:
            begin
                o_kind_reg   <= KIND_REMOVE;
                o_last_reg   <= 1'b1;
                o_delay_reg  <= pend_reg;
                o_valid_reg  <= pend_valid_reg;
                o_status_reg <= rem_match ? ST_OK : ST_NOT_FOUND;
                o_id_reg     <= rem_match ? tid_reg : '0;
            end
            S_SEL_SCAN:
            begin
                if (take)
                begin
                    bd_reg     <= dl_reg[idx_reg];
                    bid_reg    <= id_reg[idx_reg];
                    bslot_reg  <= idx_reg;
                    bfresh_reg <= fresh_reg[idx_reg];
                    biv_reg    <= iv_reg[idx_reg];
                end
            end
            S_SEL_DECIDE:
            begin
                o_status_reg <= ST_OK;
                if (stop)
                begin
                    o_kind_reg  <= KIND_FINISH;
                    o_last_reg  <= 1'b1;
                    o_id_reg    <= '0;
                    o_delay_reg <= bfound_reg ? fin_delay : '0;
                    o_valid_reg <= bfound_reg;
                end
                else
                begin
                    o_kind_reg  <= KIND_FIRE;
                    o_last_reg  <= 1'b0;
                    o_id_reg    <= bid_reg;
                    o_delay_reg <= '0;
                    o_valid_reg <= 1'b0;
                end
            end
            S_SEL_DIV:
            begin
                if (div_done)
                    dl_reg[bslot_reg] <= {1'b0, now_reg} - DL_W'(div_rem) + DL_W'(biv_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign m_tdata = {6'b0, o_valid_reg, o_delay_reg, o_id_reg, o_status_reg};
    assign m_tuser = o_kind_reg;
    assign m_tlast = o_last_reg;
endmodule

[rtl/tqs_checker.sv]
// Port checker of the timer queue scheduler and its bind.
`timescale 1ns / 1ps
`include "timer_queue_scheduler_unit_defines.svh"
module tqs_checker
    import tqs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [1:0]       s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic [1:0]       m_tuser,
    input logic             m_tlast
);
    logic fire_beat;
    logic in_beat;

    assign fire_beat = m_tvalid && (m_tuser == KIND_FIRE);
    assign in_beat   = s_tvalid && s_tready;

    `TQS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `TQS_ASSERT_SAME(a_one_side, s_tready, !m_tvalid)
    `TQS_ASSERT_SAME(a_fire_not_last, fire_beat, !m_tlast && m_tdata[57] == 1'b0)
    `TQS_ASSERT_SAME(a_add_last, m_tvalid && m_tuser == KIND_ADD, m_tlast)
    `TQS_ASSERT_NEXT(a_busy_after_in, in_beat && s_tuser != CMD_NOP, !s_tready)
endmodule

bind timer_queue_scheduler_unit tqs_checker u_tqs_checker (.*);
